[design/igcd_pkg.sv]
// Package for the integer pair gcd compare unit.
// Holds the microcode word types, the microprogram ROM and the shared constants.
// No dependencies.
package igcd_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned STEP_W         = 3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_STRIP_BOTH,
    OP_STRIP_A,
    OP_REDUCE,
    OP_FIN_A,
    OP_FIN_B
  } op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_A_ZERO,
    CND_B_ZERO,
    CND_BOTH_EVEN,
    CND_A_EVEN,
    CND_B_NONZERO
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    op_e  op;
  } dp_ctrl_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic both_even;
    logic a_even;
    logic b_nonzero;
  } dp_stat_t;

  localparam step_t STEP_CHK_A  = step_t'(0);
  localparam step_t STEP_CHK_B  = step_t'(1);
  localparam step_t STEP_STRIP2 = step_t'(2);
  localparam step_t STEP_STRIPA = step_t'(3);
  localparam step_t STEP_REDUCE = step_t'(4);
  localparam step_t STEP_FIN_A  = step_t'(5);
  localparam step_t STEP_FIN_B  = step_t'(6);

  // Binary gcd microprogram. A taken condition jumps to target, otherwise
  // the step counter advances by one. The strip ops only act when their
  // operand is even, so a step can loop on itself.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      STEP_CHK_A:  w = '{op: OP_NOP,        cond: CND_A_ZERO,    target: STEP_FIN_B};
      STEP_CHK_B:  w = '{op: OP_NOP,        cond: CND_B_ZERO,    target: STEP_FIN_A};
      STEP_STRIP2: w = '{op: OP_STRIP_BOTH, cond: CND_BOTH_EVEN, target: STEP_STRIP2};
      STEP_STRIPA: w = '{op: OP_STRIP_A,    cond: CND_A_EVEN,    target: STEP_STRIPA};
      STEP_REDUCE: w = '{op: OP_REDUCE,     cond: CND_B_NONZERO, target: STEP_REDUCE};
      STEP_FIN_A:  w = '{op: OP_FIN_A,      cond: CND_NEVER,     target: STEP_CHK_A};
      STEP_FIN_B:  w = '{op: OP_FIN_B,      cond: CND_NEVER,     target: STEP_CHK_A};
      default:     w = '{op: OP_FIN_A,      cond: CND_NEVER,     target: STEP_CHK_A};
    endcase
    return w;
  endfunction

endpackage

[design/igcd_useq.sv]
// Microcode sequencer: step counter, microprogram ROM and jump logic.
// Depends on igcd_pkg.
module igcd_useq
  import igcd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     out_blocked_i,
  input  dp_stat_t stat_i,
  output dp_ctrl_t ctrl_o,
  output logic     busy_o,
  output logic     fin_fire_o
);

  logic   busy_q, busy_d;
  step_t  step_q, step_d;
  ucode_t word;
  logic   taken;
  logic   is_fin;

  assign word   = ucode_rom(step_q);
  assign is_fin = (word.op == OP_FIN_A) || (word.op == OP_FIN_B);

  always_comb begin
    case (word.cond)
      CND_NEVER:     taken = 1'b0;
      CND_ALWAYS:    taken = 1'b1;
      CND_A_ZERO:    taken = stat_i.a_zero;
      CND_B_ZERO:    taken = stat_i.b_zero;
      CND_BOTH_EVEN: taken = stat_i.both_even;
      CND_A_EVEN:    taken = stat_i.a_even;
      CND_B_NONZERO: taken = stat_i.b_nonzero;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d     = busy_q;
    step_d     = step_q;
    fin_fire_o = 1'b0;
    ctrl_o     = '{load: start_i, op: OP_NOP};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_CHK_A;
    end else if (busy_q) begin
      if (is_fin) begin
        // A finished result waits here while the output register holds one not yet taken.
        if (!out_blocked_i) begin
          fin_fire_o = 1'b1;
          ctrl_o.op  = word.op;
          busy_d     = 1'b0;
        end
      end else begin
        ctrl_o.op = word.op;
        step_d    = taken ? word.target : step_t'(step_q + step_t'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_CHK_A;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign busy_o = busy_q;

endmodule

[design/igcd_datapath.sv]
// Binary gcd datapath: operand registers, shift count and ordering of the pair.
// Depends on igcd_pkg.
module igcd_datapath
  import igcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-1:0] first_i,
  input  logic [DATA_WIDTH-1:0] second_i,
  input  dp_ctrl_t              ctrl_i,
  output dp_stat_t              stat_o,
  output logic [DATA_WIDTH-1:0] larger_o,
  output logic [DATA_WIDTH-1:0] smaller_o,
  output logic [DATA_WIDTH-1:0] gcd_o
);

  localparam int unsigned K_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] a_q, a_d, b_q, b_d, big_q, small_q;
  logic [K_W-1:0]        k_q, k_d;
  logic                  a_gt_b;
  logic [DATA_WIDTH-1:0] diff;

  assign a_gt_b = a_q > b_q;
  assign diff   = a_gt_b ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (ctrl_i.load) begin
      a_d = first_i;
      b_d = second_i;
      k_d = '0;
    end else begin
      case (ctrl_i.op)
        OP_STRIP_BOTH: begin
          if (!a_q[0] && !b_q[0]) begin
            a_d = a_q >> 1;
            b_d = b_q >> 1;
            k_d = k_q + K_W'(1);
          end
        end
        OP_STRIP_A: begin
          if (!a_q[0]) a_d = a_q >> 1;
        end
        OP_REDUCE: begin
          // Halve b while it is even; once both are odd, keep the lesser and put the difference in b.
          if (!b_q[0]) begin
            b_d = b_q >> 1;
          end else begin
            if (a_gt_b) a_d = b_q;
            b_d = diff;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    if (ctrl_i.load) begin
      big_q   <= (first_i > second_i) ? first_i : second_i;
      small_q <= (first_i > second_i) ? second_i : first_i;
    end
  end

  assign stat_o = '{
    a_zero:    (a_q == '0),
    b_zero:    (b_q == '0),
    both_even: (!a_q[0] && !b_q[0]),
    a_even:    !a_q[0],
    b_nonzero: (b_q != '0)
  };

  assign larger_o  = big_q;
  assign smaller_o = small_q;
  assign gcd_o     = (ctrl_i.op == OP_FIN_B) ? b_q : (a_q << k_q);

endmodule

[design/integer_pair_gcd_compare_unit.sv]
// Top level of the integer pair gcd compare unit.
// Depends on igcd_pkg, igcd_useq and igcd_datapath.
//
// Usage: each item on the slave stream carries two unsigned operands. The
// unit returns one item on the master stream with the larger and smaller
// operand, the greatest common divisor, a flag that says the larger is an
// exact multiple of the smaller, and a flag that says the smaller is zero.
// The divisibility flag comes for free: the smaller value divides the larger
// exactly when it equals their gcd and is not zero.
// The gcd is found by a binary (Stein) algorithm run by a small microprogram
// that drives one shift-and-subtract datapath. An operand of zero ends the
// program early; otherwise the work is set by the subtract-and-shift loop,
// which removes bits from the operands. One item is worked on at a time;
// s_axis_tready is high whenever the sequencer is idle, also while a
// finished result still waits in the output register. When the receiver
// stalls, the result holds in that register and a following item parks in
// its final step until the register frees up. Reset clears the sequencer
// and output valid; no item is in flight after reset.
module integer_pair_gcd_compare_unit
  import igcd_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * DATA_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: first_value, second_value, zero padding.
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // Fields from bit 0 up: larger_value, smaller_value, divides_exactly,
  // gcd_value, divisor_zero, zero padding.
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic                  accept;
  logic                  busy;
  logic                  fin_fire;
  logic                  out_blocked;
  dp_ctrl_t              ctrl;
  dp_stat_t              stat;
  logic [DATA_WIDTH-1:0] larger, smaller, gcd_res;

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] larger_q, smaller_q, gcd_q;
  logic                  divides_q, dzero_q;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_blocked   = out_valid_q && !m_axis_tready;

  igcd_useq u_useq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .out_blocked_i (out_blocked),
    .stat_i        (stat),
    .ctrl_o        (ctrl),
    .busy_o        (busy),
    .fin_fire_o    (fin_fire)
  );

  igcd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .first_i   (s_axis_tdata[DATA_WIDTH-1:0]),
    .second_i  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .larger_o  (larger),
    .smaller_o (smaller),
    .gcd_o     (gcd_res)
  );

  // Output register: loaded when the program finishes, freed when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      larger_q  <= larger;
      smaller_q <= smaller;
      gcd_q     <= gcd_res;
      dzero_q   <= (smaller == '0);
      divides_q <= (smaller != '0) && (gcd_res == smaller);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({dzero_q, gcd_q, divides_q, smaller_q, larger_q});

  // A result is never written over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |-> !(out_valid_q && !m_axis_tready))
    else $error("result written while output register held");

  // An accepted item starts the sequencer.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("sequencer not busy after accept");

  // The exact-multiple flag never comes with a zero divisor.
  a_div_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(divides_q && dzero_q))
    else $error("divides flag set with zero divisor");

  // A nonzero divisor bounds the gcd.
  a_gcd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !dzero_q) |-> (gcd_q <= smaller_q && gcd_q != '0))
    else $error("gcd out of range");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for integer_pair_gcd_compare_unit: streams operand pairs,
// predicts each result on the side and compares every returned item field by field.
// Depends on igcd_pkg and the unit's RTL.
module tb_top
  import igcd_pkg::*;
;

  localparam int unsigned DW           = DATA_WIDTH_DEF;
  localparam int unsigned IN_W         = ((2 * DW + 7) / 8) * 8;
  localparam int unsigned OUT_W        = ((3 * DW + 2 + 7) / 8) * 8;
  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 8;
  // Tail wait after the last result has been taken.
  localparam int unsigned DRAIN_CYCLES = 3 * DW + 24;
  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned PAUSE_ITEM   = 1000;
  localparam int unsigned HOLD_AT      = 250;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef logic [DW-1:0] word_t;

  // One result item, with the fields that the unit packs into m_axis_tdata.
  typedef struct packed {
    word_t larger_value;
    word_t smaller_value;
    logic  divides_exactly;
    word_t gcd_value;
    logic  divisor_zero;
  } gcd_result_t;

  // One row of the directed table. Where known_result is set the expected
  // item is written out in the row; otherwise the predictor supplies it.
  typedef struct packed {
    word_t       first_value;
    word_t       second_value;
    logic        known_result;
    gcd_result_t result;
  } pair_row_t;

  localparam int unsigned DIRECTED_ROWS = 22;

  pair_row_t directed_rows [DIRECTED_ROWS] = '{
    // Both operands zero: gcd is zero, divisor flagged as zero.
    '{32'h0000_0000, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1}},
    // One operand zero, on either side: gcd is the other operand.
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1}},
    '{32'h0000_0005, 32'h0000_0000, 1'b1,
      '{32'h0000_0005, 32'h0000_0000, 1'b0, 32'h0000_0005, 1'b1}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1,
      '{32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0001, 1'b1}},
    '{32'h0000_0001, 32'h0000_0000, 1'b1,
      '{32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0001, 1'b1}},
    // Equal operands.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1,
      '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0}},
    '{32'h0000_0007, 32'h0000_0007, 1'b1,
      '{32'h0000_0007, 32'h0000_0007, 1'b1, 32'h0000_0007, 1'b0}},
    '{32'h8000_0000, 32'h8000_0000, 1'b1,
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0}},
    // Divisor of one against the extremes.
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0}},
    '{32'h8000_0000, 32'h0000_0001, 1'b1,
      '{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0}},
    // The rest come from the predictor.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h8000_0000, 32'h4000_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{32'd12,        32'd18,        1'b0, '0},
    '{32'd18,        32'd12,        1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, '0},
    '{32'h0001_0000, 32'h0003_0000, 1'b0, '0},
    '{32'd4294967291, 32'd4294967279, 1'b0, '0},
    // Consecutive Fibonacci numbers: the longest remainder chain at this width.
    '{32'd2971215073, 32'd1836311903, 1'b0, '0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // Fields from bit 0 up: first_value, second_value, zero padding.
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // Fields from bit 0 up: larger_value, smaller_value, divides_exactly,
  // gcd_value, divisor_zero, zero padding.
  logic [OUT_W-1:0] m_axis_tdata;

  // Results still owed by the unit, oldest first.
  gcd_result_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned results_count;
  logic        sender_quiet;
  logic        receiver_hold;

  integer_pair_gcd_compare_unit #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard stop in case the unit hangs or drops a result.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("integer_pair_gcd_compare_unit test failed");
    $finish;
  end

  // Ordering, divisibility and gcd of one pair, computed independently of
  // the binary datapath with the plain remainder loop.
  function automatic gcd_result_t predict_pair(input word_t a, input word_t b);
    gcd_result_t r;
    word_t       x;
    word_t       y;
    word_t       rem;
    r.larger_value    = (a > b) ? a : b;
    r.smaller_value   = (a < b) ? a : b;
    r.divisor_zero    = (r.smaller_value == '0);
    r.divides_exactly = 1'b0;
    if (!r.divisor_zero) begin
      r.divides_exactly = ((r.larger_value % r.smaller_value) == '0);
    end
    x = r.larger_value;
    y = r.smaller_value;
    while (y != '0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    r.gcd_value = x;
    return r;
  endfunction

  function automatic gcd_result_t unpack_result(input logic [OUT_W-1:0] w);
    gcd_result_t r;
    r.larger_value    = w[DW-1:0];
    r.smaller_value   = w[2*DW-1:DW];
    r.divides_exactly = w[2*DW];
    r.gcd_value       = w[3*DW:2*DW+1];
    r.divisor_zero    = w[3*DW+1];
    return r;
  endfunction

  // A value of random magnitude, so that short operands turn up as often as
  // long ones.
  function automatic word_t rand_magnitude();
    word_t v;
    v = word_t'($urandom());
    return v >> $urandom_range(DW - 1);
  endfunction

  // Random pair. Plain random words rarely share a factor, so most pairs are
  // shaped: small values, shared factors, exact multiples, equal values, zeros,
  // small values times powers of two and values near the top of the range.
  function automatic void draw_pair(output word_t a, output word_t b);
    word_t       g;
    word_t       t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      a = word_t'($urandom());
      b = word_t'($urandom());
    end else if (pick < 42) begin
      a = word_t'($urandom_range(255));
      b = word_t'($urandom_range(255));
    end else if (pick < 58) begin
      g = rand_magnitude();
      a = g * word_t'($urandom_range(1, 1000));
      b = g * word_t'($urandom_range(1, 1000));
    end else if (pick < 70) begin
      b = rand_magnitude();
      a = b * word_t'($urandom_range(0, 64));
    end else if (pick < 76) begin
      a = rand_magnitude();
      b = a;
    end else if (pick < 84) begin
      a = rand_magnitude();
      b = '0;
    end else if (pick < 93) begin
      a = word_t'($urandom_range(1, 7)) << $urandom_range(DW - 1);
      b = word_t'($urandom_range(1, 7)) << $urandom_range(DW - 1);
    end else begin
      a = '1 - word_t'($urandom_range(15));
      b = word_t'($urandom());
    end
    if ($urandom_range(1) == 1) begin
      t = a;
      a = b;
      b = t;
    end
  endfunction

  // Offers one pair and records its expected result at the edge where the
  // unit takes it. The valid is lowered only when an idle cycle follows, so
  // back-to-back items keep it high without a glitch.
  task automatic offer_pair(input word_t a, input word_t b, input gcd_result_t want);
    logic [IN_W-1:0] word;
    if (!sender_quiet) begin
      while ($urandom_range(99) < 10) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    word            = '0;
    word[DW-1:0]    = a;
    word[2*DW-1:DW] = b;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(want);
  endtask

  // Lets every outstanding result drain before the next stimulus.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: reset, the directed table, then the random pairs.
  initial begin : pair_source
    word_t a;
    word_t b;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sender_quiet  = 1'b0;
    receiver_hold = 1'b0;
    mismatch_count = 0;
    results_count  = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_pair(directed_rows[i].first_value, directed_rows[i].second_value,
                 directed_rows[i].known_result ? directed_rows[i].result :
                 predict_pair(directed_rows[i].first_value,
                              directed_rows[i].second_value));
    end
    wait_results_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // A stretch of back-to-back items from the sender.
      sender_quiet = (n >= 600) && (n < 900);
      if (n == PAUSE_ITEM) begin
        wait_results_drained();
      end
      draw_pair(a, b);
      offer_pair(a, b, predict_pair(a, b));
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("integer_pair_gcd_compare_unit test passed");
    end else begin
      $display("integer_pair_gcd_compare_unit test failed");
    end
    $finish;
  end

  // One long receiver stall while the sender keeps going, so the output
  // register fills, the next item parks and the unit drops s_axis_tready.
  initial begin : long_stall
    wait (results_count >= HOLD_AT);
    @(posedge clk_i);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    receiver_hold <= 1'b0;
  end

  task automatic note_mismatch(input string field, input word_t want, input word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch on result %0d, %s: expected %h, got %h",
               results_count, field, want, got);
    end
  endtask

  // Result side: checks every accepted item against the oldest expectation
  // and then picks the next ready value.
  initial begin : result_sink
    gcd_result_t got;
    gcd_result_t want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_result(m_axis_tdata);
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result %0d arrived with nothing outstanding: %h",
                     results_count, m_axis_tdata);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.larger_value !== want.larger_value) begin
            note_mismatch("larger_value", want.larger_value, got.larger_value);
          end
          if (got.smaller_value !== want.smaller_value) begin
            note_mismatch("smaller_value", want.smaller_value, got.smaller_value);
          end
          if (got.divides_exactly !== want.divides_exactly) begin
            note_mismatch("divides_exactly", word_t'(want.divides_exactly),
                          word_t'(got.divides_exactly));
          end
          if (got.gcd_value !== want.gcd_value) begin
            note_mismatch("gcd_value", want.gcd_value, got.gcd_value);
          end
          if (got.divisor_zero !== want.divisor_zero) begin
            note_mismatch("divisor_zero", word_t'(want.divisor_zero),
                          word_t'(got.divisor_zero));
          end
        end
        results_count++;
      end
      if (receiver_hold) begin
        m_axis_tready <= 1'b0;
      end else if ((results_count >= 1100) && (results_count < 1400)) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 10);
      end
    end
  end

endmodule
